### rtl/core/sgdd_pkg.sv
// ----------------------------------------------------------------------------
// Signed gadget digit decomposer package
// Shared widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package sgdd_pkg;

  // Field widths that do not follow the coefficient width.
  localparam int BASE_LOG_W = 5;
  localparam int LEVEL_W    = 6;
  localparam int CFG_IDX_W  = 2;

  // Largest number of levels emitted for one coefficient pair.
  localparam logic [LEVEL_W-1:0] MAX_LEVELS = LEVEL_W'(60);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_BASE_LOG    = 2'd1,
    CFG_DIGIT_COUNT = 2'd2
  } cfg_index_t;

  // Register values after reset.
  localparam longint unsigned    MODULUS_RESET     = 65537;
  localparam logic [BASE_LOG_W-1:0] BASE_LOG_RESET = BASE_LOG_W'(4);
  localparam logic [LEVEL_W-1:0] DIGIT_COUNT_RESET = LEVEL_W'(5);

endpackage

### rtl/core/signed_gadget_digit_decomposer_unit.sv
// ----------------------------------------------------------------------------
// Signed gadget digit decomposer
// Signed base-2^k digits of a coefficient pair, one level per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) moves one coefficient pair per
//   transfer. Each pair is centered against the modulus and then broken into
//   digit_count signed digits (0 counts as 1, above 60 as 60), lowest level
//   first. The output channel (out_valid / out_stall) moves one digit pair per
//   transfer, tagged with its level, a last-level flag and a copy of coef_last.
//   The centered pair is loaded into the running remainders when it is
//   accepted, and its levels are then loaded from them into the output
//   register, one level per cycle while the receiver does not stall. Each
//   lane has one digit step (mask, sign extend, arithmetic shift, modulus
//   add) that is reused once per level. in_stall stays high until the last
//   level has been loaded into the output register, so the next pair can be
//   accepted while that level still waits to be taken.
//   A receiver stall freezes the output register and, during a pair, the
//   digit sequencer. Reset clears the sequencer and the output valid, and
//   loads the registers with modulus 65537, base_log 4 and digit_count 5.
//   Configuration is written through cfg_we / cfg_index / cfg_data; the user
//   must write it only while the block is idle, which the block does not
//   enforce. Writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module signed_gadget_digit_decomposer_unit #(
  parameter int COEF_BITS = 60
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [COEF_BITS-1:0]          coef_a,
  input  logic [COEF_BITS-1:0]          coef_b,
  input  logic                          coef_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COEF_BITS-1:0]          digit_a,
  output logic [COEF_BITS-1:0]          digit_b,
  output logic [sgdd_pkg::LEVEL_W-1:0]  level,
  output logic                          level_last,
  output logic                          poly_last,
  input  logic                          cfg_we,
  input  logic [sgdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data
);
  import sgdd_pkg::*;

  // Two guard bits cover the centered range and the round-up of a digit step.
  localparam int REM_W = COEF_BITS + 2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                   state;
  logic [COEF_BITS-1:0]     modulus;
  logic [BASE_LOG_W-1:0]    base_log;
  logic [LEVEL_W-1:0]       digit_count;
  logic signed [REM_W-1:0]  rem [2];
  logic [LEVEL_W-1:0]       lvl;
  logic                     item_last;

  logic [BASE_LOG_W-1:0]    k_eff;
  logic [LEVEL_W-1:0]       n_eff;
  logic                     lvl_is_last;
  logic                     in_xfer;
  logic                     advance;
  logic [COEF_BITS-1:0]     coef [2];
  logic signed [REM_W-1:0]  rem_centered [2];
  logic signed [REM_W-1:0]  rem_next [2];
  logic signed [REM_W-1:0]  shifted_m1 [2];
  logic signed [REM_W-1:0]  dig [2];
  logic [REM_W-1:0]         dig_mapped [2];
  logic [REM_W-1:0]         digit_mask;
  logic [REM_W-1:0]         mod_ext;
  logic                     dig_neg [2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= COEF_BITS'(MODULUS_RESET);
      base_log    <= BASE_LOG_RESET;
      digit_count <= DIGIT_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:     modulus     <= cfg_data;
        CFG_BASE_LOG:    base_log    <= cfg_data[BASE_LOG_W-1:0];
        CFG_DIGIT_COUNT: digit_count <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective digit width and level count with the out-of-range codes folded.
  always_comb begin
    k_eff = (base_log == '0) ? BASE_LOG_W'(1) : base_log;
    priority if (digit_count == '0) begin
      n_eff = LEVEL_W'(1);
    end else if (digit_count > MAX_LEVELS) begin
      n_eff = MAX_LEVELS;
    end else begin
      n_eff = digit_count;
    end
  end

  assign lvl_is_last = (lvl == n_eff - LEVEL_W'(1));
  assign in_stall    = (state != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign advance     = (state == ST_RUN) && (!out_valid || !out_stall);

  // Centering of the incoming pair: keep values below q/2, else subtract q.
  assign coef[0] = coef_a;
  assign coef[1] = coef_b;
  assign mod_ext = REM_W'(modulus);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (coef[i] < (modulus >> 1)) begin
        rem_centered[i] = REM_W'(coef[i]);
      end else begin
        rem_centered[i] = REM_W'(coef[i]) - mod_ext;
      end
    end
  end

  // Shared digit step, one copy per lane. The low k bits form a signed digit;
  // removing it and shifting equals the arithmetic shift plus one when the
  // digit is negative. A negative digit is mapped up by adding q.
  assign digit_mask = ~({REM_W{1'b1}} << k_eff);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      shifted_m1[i] = rem[i] >>> (k_eff - BASE_LOG_W'(1));
      dig_neg[i]    = shifted_m1[i][0];
      dig[i]        = dig_neg[i] ? (rem[i] | ~digit_mask) : (rem[i] & digit_mask);
      rem_next[i]   = (rem[i] >>> k_eff) + signed'(REM_W'(dig_neg[i]));
      dig_mapped[i] = dig_neg[i] ? (REM_W'(dig[i]) + mod_ext) : REM_W'(dig[i]);
    end
  end

  // Sequencer, running remainders and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lvl       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new level sets the output valid; a taken level with none behind
      // it clears it.
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            rem[0]    <= rem_centered[0];
            rem[1]    <= rem_centered[1];
            item_last <= coef_last;
            lvl       <= '0;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance) begin
            rem[0]     <= rem_next[0];
            rem[1]     <= rem_next[1];
            digit_a    <= dig_mapped[0][COEF_BITS-1:0];
            digit_b    <= dig_mapped[1][COEF_BITS-1:0];
            level      <= lvl;
            level_last <= lvl_is_last;
            poly_last  <= item_last;
            if (lvl_is_last) begin
              lvl   <= '0;
              state <= ST_IDLE;
            end else begin
              lvl <= lvl + LEVEL_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/sgdd_checker.sv
// ----------------------------------------------------------------------------
// Signed gadget digit decomposer checker
// Port-level properties of the decomposer, bound to the top level.
// ----------------------------------------------------------------------------
module sgdd_checker #(
  parameter int COEF_BITS = 60
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [COEF_BITS-1:0]         digit_a,
  input logic [COEF_BITS-1:0]         digit_b,
  input logic [sgdd_pkg::LEVEL_W-1:0] level,
  input logic                         level_last,
  input logic                         poly_last
);
  import sgdd_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_a) && $stable(digit_b)
      && $stable(level) && $stable(level_last) && $stable(poly_last))
    else $error("stalled result changed");

  // Once a pair is taken the block is busy with its levels.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // While an intermediate level is shown, later levels are still pending.
  a_busy_mid_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !level_last |-> in_stall)
    else $error("input open before the last level was produced");

  // The block reopens only as the last level of a pair lands in the output.
  a_reopen_on_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid && level_last)
    else $error("input reopened without a last level");

endmodule

bind signed_gadget_digit_decomposer_unit sgdd_checker #(
  .COEF_BITS(COEF_BITS)
) u_sgdd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .digit_a    (digit_a),
  .digit_b    (digit_b),
  .level      (level),
  .level_last (level_last),
  .poly_last  (poly_last)
);
